FILE: rtl/adaptive_spin_backoff_controller_top_assert.svh
// Assertion macros for the checker file of the spin backoff controller
`ifndef ADAPTIVE_SPIN_BACKOFF_CONTROLLER_TOP_ASSERT_SVH
`define ADAPTIVE_SPIN_BACKOFF_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define ASBC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("asbc: same-cycle check failed");

// Next-cycle implication, off while reset is high
`define ASBC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("asbc: next-cycle check failed");

// Next-cycle implication that also holds through reset
`define ASBC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("asbc: check across reset failed");

`endif

FILE: rtl/asbc_pkg.sv
// Package: types, codes and reset values of the spin backoff controller
`default_nettype none

package asbc_pkg;

   // Width of the spin counter by default
   localparam int SPIN_COUNT_BITS_DEF = 16;

   // Configuration port geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPINS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPINS     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SLEEP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONGEST_SLEEP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MOST_SLEEPS   = 3'd4;

   // Register reset values
   localparam logic [15:0] MIN_SPINS_RST     = 16'd10;
   localparam logic [15:0] MAX_SPINS_RST     = 16'd1000;
   localparam logic [9:0]  FIRST_SLEEP_RST   = 10'd1;
   localparam logic [9:0]  LONGEST_SLEEP_RST = 10'd1000;
   localparam logic [9:0]  MOST_SLEEPS_RST   = 10'd1000;

   // Adaptive allowance
   localparam logic [15:0] ALLOWED_RST = 16'd100;
   localparam logic [16:0] STEP_UP     = 17'd100;

   // Rounding constant for the Q31 growth factor
   localparam logic [40:0] HALF_Q31 = 41'h0_4000_0000;

   // Action codes
   localparam logic [1:0] ACT_SPIN     = 2'd0;
   localparam logic [1:0] ACT_SLEEP    = 2'd1;
   localparam logic [1:0] ACT_ACQUIRED = 2'd2;

   // One lock attempt
   typedef struct packed {
      logic        lock_taken;
      logic [30:0] random_fraction;
   } asbc_req_type;

   // One result
   typedef struct packed {
      logic [1:0] action;
      logic [9:0] sleep_time;
      logic [9:0] sleeps_done;
      logic       timeout;
   } asbc_rsp_type;

   // Configuration registers as seen by the core
   typedef struct packed {
      logic [15:0] min_spins;
      logic [15:0] max_spins;
      logic [9:0]  first_sleep;
      logic [9:0]  longest_sleep;
      logic [9:0]  most_sleeps;
   } asbc_cfg_type;

   // Replace zero by one
   function automatic logic [9:0] at_least_one(input logic [9:0] v);
      return (v == 10'd0) ? 10'd1 : v;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/adaptive_spin_backoff_controller_top.sv
// Top level of the adaptive spin-lock backoff controller
//
//   channel | direction | handshake        | payload
//   req     | in        | req_valid/stall  | asbc_req_type (lock_taken, random_fraction)
//   rsp     | out       | rsp_valid/stall  | asbc_rsp_type (action, sleep_time, ...)
//   csr     | in/out    | psel/penable     | five registers at byte address 4*i
//
// One attempt per cycle unless rsp stalls; an attempt that transfers in is offered on rsp after
// the input register, then decision logic with one 10x31 multiply into the result register.
// The backoff state updates in the same cycle an attempt moves into the result register.
// Reset clears the stage valids and loads the register and state reset values.
// A stall on rsp holds the result register and, behind it, the input register.
`default_nettype none

module adaptive_spin_backoff_controller_top
   import asbc_pkg::*;
#(
   parameter int SPIN_COUNT_BITS = SPIN_COUNT_BITS_DEF
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire asbc_req_type          req_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      asbc_rsp_type          rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   asbc_cfg_type cfg;
   asbc_req_type in_data_ff;
   logic         in_valid_ff;
   asbc_rsp_type out_data_ff;
   logic         out_valid_ff;
   asbc_rsp_type step_rsp;
   logic         advance;

   asbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   asbc_core #(
      .SPIN_COUNT_BITS (SPIN_COUNT_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   // Move an attempt on when the result register is free or being emptied
   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/asbc_csr.sv
// Configuration register file with an APB-style access port
`default_nettype none

module asbc_csr
   import asbc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready,
   output      asbc_cfg_type          cfg
);

   asbc_cfg_type         cfg_ff;
   logic                 wr_en;
   logic [CSR_IDX_W-1:0] idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg        = cfg_ff;

   // Write the addressed register at the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_spins     <= MIN_SPINS_RST;
         cfg_ff.max_spins     <= MAX_SPINS_RST;
         cfg_ff.first_sleep   <= FIRST_SLEEP_RST;
         cfg_ff.longest_sleep <= LONGEST_SLEEP_RST;
         cfg_ff.most_sleeps   <= MOST_SLEEPS_RST;
      end else if (wr_en) begin
         unique case (idx)
            CSR_MIN_SPINS:     cfg_ff.min_spins     <= csr_pwdata[15:0];
            CSR_MAX_SPINS:     cfg_ff.max_spins     <= csr_pwdata[15:0];
            CSR_FIRST_SLEEP:   cfg_ff.first_sleep   <= csr_pwdata[9:0];
            CSR_LONGEST_SLEEP: cfg_ff.longest_sleep <= csr_pwdata[9:0];
            CSR_MOST_SLEEPS:   cfg_ff.most_sleeps   <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   // Return the addressed register, zero outside the map
   always_comb begin
      unique case (idx)
         CSR_MIN_SPINS:     csr_prdata = CSR_DATA_W'(cfg_ff.min_spins);
         CSR_MAX_SPINS:     csr_prdata = CSR_DATA_W'(cfg_ff.max_spins);
         CSR_FIRST_SLEEP:   csr_prdata = CSR_DATA_W'(cfg_ff.first_sleep);
         CSR_LONGEST_SLEEP: csr_prdata = CSR_DATA_W'(cfg_ff.longest_sleep);
         CSR_MOST_SLEEPS:   csr_prdata = CSR_DATA_W'(cfg_ff.most_sleeps);
         default:           csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/asbc_core.sv
// Backoff state and the per-attempt decision logic
`default_nettype none

module asbc_core
   import asbc_pkg::*;
#(
   parameter int SPIN_COUNT_BITS = SPIN_COUNT_BITS_DEF
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step_en,
   input  wire asbc_req_type req,
   input  wire asbc_cfg_type cfg,
   output      asbc_rsp_type rsp
);

   localparam int CMP_W = (SPIN_COUNT_BITS > 16) ? SPIN_COUNT_BITS : 16;

   logic [SPIN_COUNT_BITS-1:0] spin_count_ff, spin_count_in;
   logic [9:0]                 sleep_count_ff, sleep_count_in;
   logic [9:0]                 backoff_time_ff, backoff_time_in;
   logic [15:0]                spins_allowed_ff, spins_allowed_in;

   logic [SPIN_COUNT_BITS-1:0] spin_inc;
   logic                       sleep_now;
   logic [9:0]                 sleep_inc;
   logic [9:0]                 b_use;
   logic [9:0]                 cap;
   logic [40:0]                prod;
   logic [40:0]                rounded;
   logic [10:0]                grown;
   logic [16:0]                up;
   logic [15:0]                down;

   // Counted spin, saturating at the counter's top
   assign spin_inc  = (&spin_count_ff) ? spin_count_ff : spin_count_ff + 1'b1;
   assign sleep_now = CMP_W'(spin_inc) >= CMP_W'(spins_allowed_ff);

   // Sleep count, saturating at the limit and at the field's top
   assign sleep_inc = ((sleep_count_ff < cfg.most_sleeps) && !(&sleep_count_ff))
                      ? sleep_count_ff + 10'd1 : sleep_count_ff;

   // Grow the backoff by b * r / 2^31, rounded half up, then clamp
   assign b_use   = (backoff_time_ff == 10'd0) ? at_least_one(cfg.first_sleep)
                                               : backoff_time_ff;
   assign cap     = at_least_one(cfg.longest_sleep);
   assign prod    = 41'(b_use) * 41'(req.random_fraction);
   assign rounded = prod + HALF_Q31;
   assign grown   = {1'b0, b_use} + {1'b0, rounded[40:31]};

   // Allowance steps
   assign up   = {1'b0, spins_allowed_ff} + STEP_UP;
   assign down = spins_allowed_ff - 16'd1;

   // Next state and result of one attempt
   always_comb begin
      spin_count_in    = spin_count_ff;
      sleep_count_in   = sleep_count_ff;
      backoff_time_in  = backoff_time_ff;
      spins_allowed_in = spins_allowed_ff;
      rsp.action       = ACT_SPIN;
      rsp.sleep_time   = 10'd0;
      rsp.sleeps_done  = 10'd0;
      rsp.timeout      = sleep_count_ff >= cfg.most_sleeps;
      if (req.lock_taken) begin
         rsp.action      = ACT_ACQUIRED;
         rsp.sleeps_done = sleep_count_ff;
         // Adapt the allowance: up when the acquire never slept, down when it did
         if (backoff_time_ff == 10'd0) begin
            if (spins_allowed_ff < cfg.max_spins) begin
               spins_allowed_in = (up < {1'b0, cfg.max_spins}) ? up[15:0] : cfg.max_spins;
            end
         end else if (spins_allowed_ff > cfg.min_spins) begin
            spins_allowed_in = (down > cfg.min_spins) ? down : cfg.min_spins;
         end
         spin_count_in   = '0;
         sleep_count_in  = 10'd0;
         backoff_time_in = 10'd0;
      end else if (sleep_now) begin
         rsp.action      = ACT_SLEEP;
         rsp.sleep_time  = b_use;
         rsp.timeout     = sleep_inc >= cfg.most_sleeps;
         sleep_count_in  = sleep_inc;
         backoff_time_in = (grown > {1'b0, cap}) ? cap : grown[9:0];
         spin_count_in   = '0;
      end else begin
         spin_count_in = spin_inc;
      end
   end

   // Advance the state once per transfer into the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         spin_count_ff    <= '0;
         sleep_count_ff   <= 10'd0;
         backoff_time_ff  <= 10'd0;
         spins_allowed_ff <= ALLOWED_RST;
      end else if (step_en) begin
         spin_count_ff    <= spin_count_in;
         sleep_count_ff   <= sleep_count_in;
         backoff_time_ff  <= backoff_time_in;
         spins_allowed_ff <= spins_allowed_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/asbc_checker.sv
// Port-level checks of the spin backoff controller, bound to the top level
`default_nettype none
`include "adaptive_spin_backoff_controller_top_assert.svh"

module asbc_checker
   import asbc_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire asbc_rsp_type rsp_data
);

   // A stalled result stays offered
   `ASBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // Reset empties the result register
   `ASBC_ASSERT_NEXT_ALWAYS(a_rsp_reset, clock, reset, !rsp_valid)

   // Sleep time only on a sleep, and a sleep is never zero long
   `ASBC_ASSERT_NOW(a_time_zero, clock, reset, rsp_valid && rsp_data.action != ACT_SLEEP, rsp_data.sleep_time == 10'd0)
   `ASBC_ASSERT_NOW(a_time_set, clock, reset, rsp_valid && rsp_data.action == ACT_SLEEP, rsp_data.sleep_time != 10'd0)

   // Sleep count reported only on an acquire
   `ASBC_ASSERT_NOW(a_done_zero, clock, reset, rsp_valid && rsp_data.action != ACT_ACQUIRED, rsp_data.sleeps_done == 10'd0)

endmodule

bind adaptive_spin_backoff_controller_top asbc_checker u_asbc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the adaptive spin-lock backoff controller: decision tracker and stimulus driver

import asbc_pkg::*;

// Tracks the controller state, predicts each decision and checks the results
class backoff_tracker;
   localparam int          CNT_W      = SPIN_COUNT_BITS_DEF;
   localparam logic [63:0] ROUND_HALF = 64'h4000_0000;
   localparam logic [16:0] RISE_STEP  = 17'd100;
   localparam int          REPORT_CAP = 60;

   // Register copies
   logic [15:0] min_spins;
   logic [15:0] max_spins;
   logic [9:0]  first_sleep;
   logic [9:0]  longest_sleep;
   logic [9:0]  most_sleeps;

   // Controller state
   logic [CNT_W-1:0] spin_count;
   logic [9:0]       sleep_count;
   logic [9:0]       backoff;
   logic [15:0]      allowed;

   asbc_rsp_type due_decisions[$];
   int errors, attempts, sleeps, acquires, timeouts, checked;

   function new();
      min_spins     = MIN_SPINS_RST;
      max_spins     = MAX_SPINS_RST;
      first_sleep   = FIRST_SLEEP_RST;
      longest_sleep = LONGEST_SLEEP_RST;
      most_sleeps   = MOST_SLEEPS_RST;
      spin_count    = '0;
      sleep_count   = '0;
      backoff       = '0;
      allowed       = ALLOWED_RST;
      errors        = 0;
      attempts      = 0;
      sleeps        = 0;
      acquires      = 0;
      timeouts      = 0;
      checked       = 0;
   endfunction

   function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
         CSR_MIN_SPINS:     min_spins     = value[15:0];
         CSR_MAX_SPINS:     max_spins     = value[15:0];
         CSR_FIRST_SLEEP:   first_sleep   = value[9:0];
         CSR_LONGEST_SLEEP: longest_sleep = value[9:0];
         CSR_MOST_SLEEPS:   most_sleeps   = value[9:0];
         default: ;
      endcase
   endfunction

   function logic [31:0] reg_value(logic [CSR_IDX_W-1:0] idx);
      case (idx)
         CSR_MIN_SPINS:     return 32'(min_spins);
         CSR_MAX_SPINS:     return 32'(max_spins);
         CSR_FIRST_SLEEP:   return 32'(first_sleep);
         CSR_LONGEST_SLEEP: return 32'(longest_sleep);
         CSR_MOST_SLEEPS:   return 32'(most_sleeps);
         default:           return 32'd0;
      endcase
   endfunction

   function void complain(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= REPORT_CAP)
         $error("%s mismatch: expected %0d, got %0d", what, want, got);
   endfunction

   // Advance the state by one lock attempt and queue the decision it yields
   function void note_attempt(asbc_req_type a);
      asbc_rsp_type d;
      logic [63:0]  grown;
      logic [16:0]  up;
      logic [9:0]   cap;
      d = '0;
      attempts++;
      if (a.lock_taken) begin
         d.action      = ACT_ACQUIRED;
         d.sleeps_done = sleep_count;
         d.timeout     = (sleep_count >= most_sleeps);
         // Adapt the allowance: rise without a sleep, fall after one
         if (backoff == 10'd0) begin
            if (allowed < max_spins) begin
               up      = {1'b0, allowed} + RISE_STEP;
               allowed = (up < {1'b0, max_spins}) ? up[15:0] : max_spins;
            end
         end else if (allowed > min_spins) begin
            allowed = (allowed - 16'd1 > min_spins) ? allowed - 16'd1 : min_spins;
         end
         spin_count  = '0;
         sleep_count = '0;
         backoff     = '0;
         acquires++;
      end else begin
         if (spin_count != '1)
            spin_count++;
         // Allowance used up: order a sleep, then grow the backoff
         if (spin_count >= allowed) begin
            cap = (longest_sleep == 10'd0) ? 10'd1 : longest_sleep;
            if (sleep_count < most_sleeps && sleep_count != 10'h3FF)
               sleep_count++;
            if (backoff == 10'd0)
               backoff = (first_sleep == 10'd0) ? 10'd1 : first_sleep;
            d.action     = ACT_SLEEP;
            d.sleep_time = backoff;
            grown = 64'(backoff) +
                    ((64'(backoff) * 64'(a.random_fraction) + ROUND_HALF) >> 31);
            if (grown > 64'(cap))
               grown = 64'(cap);
            backoff    = grown[9:0];
            spin_count = '0;
            sleeps++;
         end
         d.timeout = (sleep_count >= most_sleeps);
      end
      if (d.timeout)
         timeouts++;
      due_decisions.push_back(d);
   endfunction

   // Compare one result transfer with the oldest predicted decision
   function void check_decision(asbc_rsp_type got);
      asbc_rsp_type want;
      if (due_decisions.size() == 0) begin
         errors++;
         if (errors <= REPORT_CAP)
            $error("result with no attempt pending: action %0d", got.action);
         return;
      end
      want = due_decisions.pop_front();
      checked++;
      if (got.action !== want.action)
         complain("action", want.action, got.action);
      if (got.sleep_time !== want.sleep_time)
         complain("sleep_time", want.sleep_time, got.sleep_time);
      if (got.sleeps_done !== want.sleeps_done)
         complain("sleeps_done", want.sleeps_done, got.sleeps_done);
      if (got.timeout !== want.timeout)
         complain("timeout", want.timeout, got.timeout);
   endfunction
endclass

module tb_top;
   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   asbc_req_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   asbc_rsp_type          rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   backoff_tracker book;
   bit             calm;
   int             sent;
   string          reg_names [0:4] = '{"min_spins", "max_spins", "first_sleep",
                                       "longest_sleep", "most_sleeps"};

   adaptive_spin_backoff_controller_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Check result transfers and stall the result side at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         book.check_decision(rsp_data);
      rsp_stall <= !calm && ($urandom_range(99, 0) < 7);
   end

   // Present one attempt, with random gaps, and hold it until the transfer
   task automatic try_lock(input bit taken, input logic [30:0] frac);
      asbc_req_type a;
      a.lock_taken      = taken;
      a.random_fraction = frac;
      while (!calm && $urandom_range(99, 0) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= a;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      book.note_attempt(a);
      sent++;
   endtask

   // Spin until the allowance is used up; the last failed attempt orders a sleep
   task automatic sleep_once(input logic [30:0] frac);
      while (int'(book.spin_count) + 1 < int'(book.allowed))
         try_lock(1'b0, 31'($urandom()));
      try_lock(1'b0, frac);
   endtask

   // Failed attempts followed by the one that takes the lock
   task automatic run_acquire(input int fails);
      repeat (fails)
         try_lock(1'b0, 31'($urandom()));
      try_lock(1'b1, 31'($urandom()));
   endtask

   // Drop valid and wait until every decision has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (book.due_decisions.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      book.set_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_reg(input logic [CSR_IDX_W-1:0] idx, output logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_regs();
      logic [31:0] v;
      for (int i = 0; i < 5; i++) begin
         read_reg(CSR_IDX_W'(i), v);
         if (v !== book.reg_value(CSR_IDX_W'(i)))
            book.complain(reg_names[i], book.reg_value(CSR_IDX_W'(i)), v);
      end
   endtask

   task automatic apply_settings(input int lo, input int hi, input int first,
                                 input int longest, input int most);
      settle();
      write_reg(CSR_MIN_SPINS, 32'(lo));
      write_reg(CSR_MAX_SPINS, 32'(hi));
      write_reg(CSR_FIRST_SLEEP, 32'(first));
      write_reg(CSR_LONGEST_SLEEP, 32'(longest));
      write_reg(CSR_MOST_SLEEPS, 32'(most));
      check_regs();
   endtask

   // Failure run for one acquire: half quick grabs, half usually enough to sleep
   function automatic int plan_fails(input int allowance);
      int top;
      if ($urandom_range(9, 0) < 5)
         return int'($urandom_range(3, 0));
      top = allowance + allowance / 4 + 3;
      if (top > 160)
         return int'($urandom_range(160, 0));
      return int'($urandom_range(top, allowance));
   endfunction

   task automatic run_phase(input int budget);
      int start;
      start = sent;
      while (sent - start < budget)
         run_acquire(plan_fails(int'(book.allowed)));
   endtask

   initial begin
      book        = new();
      calm        = 1'b0;
      sent        = 0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      rsp_stall   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_regs();

      // First sleep above the clamp, then growth clamped down to one
      apply_settings(1, 1, 1023, 1, 1023);
      sleep_once(31'h7FFF_FFFF);
      sleep_once(31'h0);
      try_lock(1'b1, 31'h7FFF_FFFF);

      // Zero sleep settings act as one; zero sleep limit keeps timeout high
      apply_settings(1, 1, 0, 0, 0);
      sleep_once(31'h7FFF_FFFF);
      sleep_once(31'h0);
      try_lock(1'b1, 31'h0);

      // Rounding at exactly one half, growth, and sleep count saturation
      apply_settings(1, 1, 1, 1023, 2);
      sleep_once(31'h4000_0000);
      sleep_once(31'h3FFF_FFFF);
      sleep_once(31'h7FFF_FFFF);
      try_lock(1'b1, 31'h0);

      // Rise clamped at the upper bound, then bounds crossed
      apply_settings(1, int'(book.allowed) + 1, 1, 1023, 1023);
      try_lock(1'b1, 31'h0);
      apply_settings(4, 2, 1, 1023, 1023);
      run_acquire(5);
      try_lock(1'b1, 31'h7FFF_FFFF);

      // Random acquires under several settings
      apply_settings(1, 4, $urandom_range(1023, 1), $urandom_range(1023, 1),
                     $urandom_range(30, 1));
      run_phase(50);
      apply_settings(0, 0, 0, 1023, 1023);
      run_phase(50);
      apply_settings(65535, 6, $urandom_range(1023, 0), $urandom_range(40, 1), 0);
      run_phase(50);
      calm = 1'b1;
      apply_settings(2, 10, $urandom_range(1023, 0), $urandom_range(1023, 0),
                     $urandom_range(60, 0));
      run_phase(50);
      calm = 1'b0;
      apply_settings($urandom_range(20, 0), 65535, $urandom_range(1023, 0),
                     $urandom_range(1023, 0), $urandom_range(1023, 0));
      run_phase(50);

      // Drain and let the pipeline go quiet
      settle();
      repeat (8) @(posedge clock);
      $display("Run covered %0d lock attempts: %0d sleeps, %0d acquires, %0d timeouts.",
               book.attempts, book.sleeps, book.acquires, book.timeouts);
      $display("Compared %0d results, %0d mismatches.", book.checked, book.errors);
      if (book.errors == 0 && book.due_decisions.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Stop a hung run
   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+rtl
rtl/asbc_pkg.sv
rtl/asbc_csr.sv
rtl/asbc_core.sv
rtl/adaptive_spin_backoff_controller_top.sv
rtl/asbc_checker.sv
dv/tb_top.sv
